### hdl/row_run_star_edge_detector_defines.svh
// Assertion macros used by the back end of the edge detector.
`ifndef ROW_RUN_STAR_EDGE_DETECTOR_DEFINES_SVH
`define ROW_RUN_STAR_EDGE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RRSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define RRSE_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define RRSE_ASSERT(label, clk, rst, prop)
`define RRSE_ASSERT_NR(label, clk, prop)
`endif
`endif

### hdl/rrse_pkg.sv
// Types and constants of the row run edge detector.
package rrse_pkg;
   localparam int PIXEL_BITS = 16;
   localparam int WACC_BITS = 40;
   localparam int LACC_BITS = 28;
   localparam int CNT_BITS = 13;
   localparam int Q_BITS = 44;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_BLACK = 2'd1,
      REG_BAD_LIMIT = 2'd2,
      REG_MIN_WIDTH = 2'd3
   } reg_index_type;
   localparam logic [2:0] REG_ROW_LENGTH = 3'd4;

   typedef struct packed {
      logic [11:0] row;
      logic [WACC_BITS-1:0] weighted;
      logic [LACC_BITS-1:0] sum;
      logic [CNT_BITS-1:0] width;
   } run_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV = 3'b010,
      ST_READ = 3'b100
   } back_state_type;
endpackage

### hdl/rrse_front.sv
// Front end: black subtraction, run tracking, line store writes and run close.
module rrse_front #(
   parameter int MAX_ROW_PIXELS = 4096,
   parameter int COL_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [15:0] in_pixel,
   input  logic in_frame_start,
   input  logic [15:0] thr,
   input  logic [15:0] black,
   input  logic [3:0] bad_limit,
   input  logic [12:0] min_width,
   input  logic [12:0] row_length,
   output logic row_start,
   output logic wr_en,
   output logic [COL_BITS-1:0] wr_addr,
   output logic [15:0] wr_data,
   output logic run_push,
   output rrse_pkg::run_type run_out
);
   import rrse_pkg::*;
   localparam int COL_W = COL_BITS + 1;
   logic [WACC_BITS-1:0] wacc_ff, wacc_in;
   logic [LACC_BITS-1:0] lacc_ff, lacc_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [4:0] miss_ff, miss_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic [PIXEL_BITS-1:0] raw;
   logic [16:0] level17;
   logic [15:0] level;
   logic [COL_BITS-1:0] col;
   logic [11:0] row;
   logic [12:0] rl;
   logic [WACC_BITS-1:0] cw, wa, la, ca;
   logic [CNT_BITS-1:0] ccnt;
   logic [4:0] cmiss;
   logic [WACC_BITS:0] wsum;
   logic [LACC_BITS:0] lsum;
   logic take, last;

   assign row_start = (col_ff == '0);

   always_comb begin
      raw = in_pixel[PIXEL_BITS-1:0];
      level17 = 17'(raw) - 17'(black);
      level = (17'(raw) > 17'(black)) ? level17[15:0] : 16'd0;
      col = in_frame_start ? '0 : col_ff;
      row = in_frame_start ? 12'd0 : row_ff;
      wa = (col == '0) ? '0 : wacc_ff;
      la = (col == '0) ? '0 : WACC_BITS'(lacc_ff);
      ccnt = (col == '0) ? '0 : cnt_ff;
      cmiss = (col == '0) ? '0 : miss_ff;
      rl = row_length;
      if (rl == 13'd0) rl = 13'd1;
      if (32'(rl) > MAX_ROW_PIXELS) rl = 13'(MAX_ROW_PIXELS);
      take = (level >= thr) || (ccnt != '0 && cmiss <= 5'(bad_limit));
      cw = WACC_BITS'(col) * WACC_BITS'(level);
      wsum = {1'b0, wa} + {1'b0, cw};
      lsum = {1'b0, la[LACC_BITS-1:0]} + (LACC_BITS+1)'(level);
      run_push = 1'b0;
      run_out.row = row;
      run_out.weighted = wa;
      run_out.sum = la[LACC_BITS-1:0];
      run_out.width = ccnt;
      wacc_in = wa;
      lacc_in = la[LACC_BITS-1:0];
      cnt_in = ccnt;
      miss_in = cmiss;
      ca = '0;
      if (take) begin
         miss_in = (level < thr) ? cmiss + 5'd1 : 5'd0;
         wacc_in = wsum[WACC_BITS] ? '1 : wsum[WACC_BITS-1:0];
         lacc_in = lsum[LACC_BITS] ? '1 : lsum[LACC_BITS-1:0];
         cnt_in = (ccnt == '1) ? ccnt : ccnt + 1'b1;
      end else if (ccnt != '0) begin
         run_push = in_valid && ccnt >= min_width && wa != '0 && la != ca;
         wacc_in = '0;
         lacc_in = '0;
         cnt_in = '0;
         miss_in = '0;
      end
      last = (COL_W'(col) + 1'b1) >= COL_W'(rl);
      if (last) begin
         wacc_in = '0;
         lacc_in = '0;
         cnt_in = '0;
         miss_in = '0;
         col_in = '0;
         row_in = row + 12'd1;
      end else begin
         col_in = col + 1'b1;
         row_in = row;
      end
      wr_en = in_valid;
      wr_addr = col;
      wr_data = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wacc_ff <= '0;
         lacc_ff <= '0;
         cnt_ff <= '0;
         miss_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_valid) begin
         wacc_ff <= wacc_in;
         lacc_ff <= lacc_in;
         cnt_ff <= cnt_in;
         miss_ff <= miss_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end
endmodule

### hdl/rrse_back.sv
// Back end: run queue, serial centroid divider, line store and result register.
module rrse_back #(
   parameter int COL_BITS = 12,
   parameter int MAX_ROW_PIXELS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [COL_BITS-1:0] wr_addr,
   input  logic [15:0] wr_data,
   input  logic run_push,
   input  rrse_pkg::run_type run_in,
   output logic q_full,
   output logic q_empty,
   output logic busy,
   output logic out_valid,
   input  logic out_stall,
   output logic [11:0] out_row,
   output logic [15:0] out_center,
   output logic [12:0] out_width,
   output logic [27:0] out_sum,
   output logic [15:0] out_level
);
   import rrse_pkg::*;
   `include "row_run_star_edge_detector_defines.svh"
   logic [15:0] mem [MAX_ROW_PIXELS];
   logic [15:0] rd_ff;
   run_type q_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic pop;
   back_state_type st_ff, st_in;
   run_type cur_ff;
   logic [Q_BITS-1:0] quo_ff;
   logic [LACC_BITS:0] rem_ff;
   logic [5:0] step_ff;
   logic [LACC_BITS+1:0] trial;
   logic [Q_BITS-1:0] rc;
   logic rc_ok;
   logic ov_ff;
   logic o_ok_ff;
   logic [11:0] o_row_ff;
   logic [15:0] o_c_ff;
   logic [12:0] o_w_ff;
   logic [27:0] o_s_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (st_ff == ST_READ) rd_ff <= mem[rc[COL_BITS-1:0]];
   end

   assign q_full = cnt_ff == 2'd2;
   assign q_empty = cnt_ff == 2'd0;
   assign busy = st_ff != ST_IDLE;
   assign pop = st_ff == ST_IDLE && !q_empty && !ov_ff;
   assign trial = {rem_ff, quo_ff[Q_BITS-1]} - (LACC_BITS+2)'(cur_ff.sum);
   assign rc = (quo_ff + Q_BITS'(8)) >> 4;
   assign rc_ok = rc < Q_BITS'(MAX_ROW_PIXELS);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (pop) st_in = ST_DIV;
         ST_DIV: if (step_ff == 6'(Q_BITS - 1)) st_in = ST_READ;
         ST_READ: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (run_push) begin
            q_ff[wp_ff] <= run_in;
            wp_ff <= !wp_ff;
         end
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(run_push) - 2'(pop);
         if (st_ff == ST_READ) ov_ff <= 1'b1;
         else if (ov_ff && !out_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_ff[rp_ff];
         quo_ff <= {q_ff[rp_ff].weighted, 4'd0};
         rem_ff <= '0;
         step_ff <= '0;
      end else if (st_ff == ST_DIV) begin
         step_ff <= step_ff + 6'd1;
         if (!trial[LACC_BITS+1]) begin
            rem_ff <= trial[LACC_BITS:0];
            quo_ff <= {quo_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[LACC_BITS-1:0], quo_ff[Q_BITS-1]};
            quo_ff <= {quo_ff[Q_BITS-2:0], 1'b0};
         end
      end
      if (st_ff == ST_READ) begin
         o_row_ff <= cur_ff.row;
         o_c_ff <= (quo_ff > Q_BITS'(16'hFFFF)) ? 16'hFFFF : quo_ff[15:0];
         o_w_ff <= cur_ff.width;
         o_s_ff <= cur_ff.sum;
         o_ok_ff <= rc_ok;
      end
   end

   assign out_valid = ov_ff;
   assign out_row = o_row_ff;
   assign out_center = o_c_ff;
   assign out_width = o_w_ff;
   assign out_sum = o_s_ff;
   assign out_level = o_ok_ff ? rd_ff : 16'd0;

   `RRSE_ASSERT(a_q_bound, clock, reset, cnt_ff != 2'd3)
   `RRSE_ASSERT(a_no_overflow, clock, reset, !(q_full && run_push && !pop))
   `RRSE_ASSERT(a_hold, clock, reset, (ov_ff && out_stall) |=> ov_ff && $stable(o_c_ff))
endmodule

### hdl/row_run_star_edge_detector.sv
// Top level of the row run edge detector.
// Pixels are taken one per cycle while req_stall is low; each closed run that qualifies
// goes into a two-entry queue. The back end takes a run from the queue, works it through
// a serial divider, then reads the line store and loads the result register, and the
// next run leaves the queue only once that result has been taken. req_stall rises
// while the run queue is full, and also on the first pixel of a row or of a frame
// while any run is still queued, being divided or being read, so that its line store
// entries are not overwritten before they are read. The line store needs no clearing.
module row_run_star_edge_detector #(
   parameter int MAX_ROW_PIXELS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_pixel,
   input  logic req_frame_start,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [11:0] rsp_edge_row,
   output logic [15:0] rsp_center_column,
   output logic [12:0] rsp_run_width,
   output logic [27:0] rsp_run_sum,
   output logic [15:0] rsp_center_level,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data
);
   import rrse_pkg::*;
   localparam int COL_BITS = $clog2(MAX_ROW_PIXELS);
   logic [15:0] thr_ff, black_ff;
   logic [3:0] bad_ff;
   logic [12:0] minw_ff, rowl_ff;
   logic acc;
   logic wr_en, run_push, q_full, q_empty, back_busy, row_start;
   logic [COL_BITS-1:0] wr_addr;
   logic [15:0] wr_data;
   run_type run_w;

   assign csr_ready = 1'b1;
   assign req_stall = q_full ||
      ((req_frame_start || row_start) && (!q_empty || back_busy));
   assign acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         black_ff <= '0;
         bad_ff <= 4'd2;
         minw_ff <= 13'd3;
         rowl_ff <= 13'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            3'(REG_THRESHOLD): thr_ff <= csr_data;
            3'(REG_BLACK): black_ff <= csr_data;
            3'(REG_BAD_LIMIT): bad_ff <= csr_data[3:0];
            3'(REG_MIN_WIDTH): minw_ff <= csr_data[12:0];
            REG_ROW_LENGTH: rowl_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   rrse_front #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS), .COL_BITS(COL_BITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(acc), .in_pixel(req_pixel),
      .in_frame_start(req_frame_start), .thr(thr_ff), .black(black_ff),
      .bad_limit(bad_ff), .min_width(minw_ff), .row_length(rowl_ff),
      .row_start(row_start), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .run_push(run_push), .run_out(run_w));

   rrse_back #(.COL_BITS(COL_BITS), .MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_back (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .run_push(run_push), .run_in(run_w), .q_full(q_full),
      .q_empty(q_empty), .busy(back_busy), .out_valid(rsp_valid),
      .out_stall(rsp_stall), .out_row(rsp_edge_row), .out_center(rsp_center_column),
      .out_width(rsp_run_width), .out_sum(rsp_run_sum),
      .out_level(rsp_center_level));
endmodule

### verif/row_run_star_edge_detector_checker.sv
// Checker of the row run edge detector: it predicts each result and compares it field by field.
module row_run_star_edge_detector_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [15:0] req_pixel,
   input  logic req_frame_start,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [11:0] rsp_edge_row,
   input  logic [15:0] rsp_center_column,
   input  logic [12:0] rsp_run_width,
   input  logic [27:0] rsp_run_sum,
   input  logic [15:0] rsp_center_level,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data,
   output int errors,
   output int pending
);
   import rrse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [11:0] row;
      logic [15:0] column;
      logic [12:0] width;
      logic [27:0] sum;
      logic [15:0] level;
   } star_edge_type;

   star_edge_type edge_queue[$];

   logic [15:0] threshold_q;
   logic [15:0] black_q;
   logic [3:0] bad_limit_q;
   logic [12:0] min_width_q;
   logic [12:0] row_length_q;

   logic [15:0] line_levels[4096];
   logic [WACC_BITS-1:0] weighted_sum;
   logic [LACC_BITS-1:0] level_sum;
   logic [CNT_BITS-1:0] run_pixels;
   logic [4:0] miss_run;
   int column_q;
   logic [11:0] row_q;

   assign pending = edge_queue.size();

   task automatic report_mismatch(input string field, input longint expected,
                                  input longint actual);
      $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
      errors++;
   endtask

   function automatic void drop_run();
      weighted_sum = '0;
      level_sum = '0;
      run_pixels = '0;
      miss_run = '0;
   endfunction

   task automatic track_pixel(input logic [15:0] pixel, input logic frame_start);
      logic [15:0] level;
      int limit;
      logic [47:0] grown;
      logic [47:0] centroid;
      logic [47:0] rounded;
      star_edge_type found;
      level = pixel > black_q ? pixel - black_q : 16'd0;
      limit = row_length_q == 0 ? 1 : (row_length_q > 4096 ? 4096 : row_length_q);
      if (frame_start) begin
         column_q = 0;
         row_q = '0;
      end
      if (column_q == 0) drop_run();
      line_levels[column_q] = level;
      if (level >= threshold_q || (run_pixels > 0 && miss_run <= bad_limit_q)) begin
         if (level < threshold_q) miss_run++;
         else miss_run = '0;
         grown = 48'(weighted_sum) + 48'(column_q) * 48'(level);
         weighted_sum = grown > 48'(40'hFF_FFFF_FFFF) ? '1 : grown[WACC_BITS-1:0];
         grown = 48'(level_sum) + 48'(level);
         level_sum = grown > 48'(28'hFFF_FFFF) ? '1 : grown[LACC_BITS-1:0];
         if (run_pixels != '1) run_pixels++;
      end else if (run_pixels > 0) begin
         if (run_pixels >= min_width_q && weighted_sum > 0 && level_sum > 0) begin
            centroid = {weighted_sum, 4'b0} / 48'(level_sum);
            rounded = (centroid + 48'd8) >> 4;
            found.row = row_q;
            found.column = centroid > 48'hFFFF ? 16'hFFFF : centroid[15:0];
            found.width = run_pixels;
            found.sum = level_sum;
            found.level = rounded < 4096 ? line_levels[rounded[11:0]] : 16'd0;
            edge_queue.push_back(found);
         end
         drop_run();
      end
      if (column_q + 1 >= limit) begin
         drop_run();
         column_q = 0;
         row_q++;
      end else begin
         column_q++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold_q = '0;
         black_q = '0;
         bad_limit_q = 4'd2;
         min_width_q = 13'd3;
         row_length_q = 13'd4096;
         drop_run();
         column_q = 0;
         row_q = '0;
         edge_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               {1'b0, REG_THRESHOLD}: threshold_q = csr_data;
               {1'b0, REG_BLACK}: black_q = csr_data;
               {1'b0, REG_BAD_LIMIT}: bad_limit_q = csr_data[3:0];
               {1'b0, REG_MIN_WIDTH}: min_width_q = csr_data[12:0];
               REG_ROW_LENGTH: row_length_q = csr_data[12:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (edge_queue.size() == 0) begin
               $display("%0t: result with none expected", $time);
               errors++;
            end else begin
               star_edge_type exp_edge;
               exp_edge = edge_queue.pop_front();
               if (rsp_edge_row !== exp_edge.row)
                  report_mismatch("edge_row", exp_edge.row, rsp_edge_row);
               if (rsp_center_column !== exp_edge.column)
                  report_mismatch("center_column", exp_edge.column, rsp_center_column);
               if (rsp_run_width !== exp_edge.width)
                  report_mismatch("run_width", exp_edge.width, rsp_run_width);
               if (rsp_run_sum !== exp_edge.sum)
                  report_mismatch("run_sum", exp_edge.sum, rsp_run_sum);
               if (rsp_center_level !== exp_edge.level)
                  report_mismatch("center_level", exp_edge.level, rsp_center_level);
            end
         end
         if (req_valid && !req_stall) track_pixel(req_pixel, req_frame_start);
      end
   end

   initial errors = 0;
endmodule

### verif/row_run_star_edge_detector_tb.sv
// Testbench top of the row run edge detector: stimulus, flow control and verdict.
module row_run_star_edge_detector_tb;
   import rrse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_pixel = '0;
   logic req_frame_start = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [11:0] rsp_edge_row;
   logic [15:0] rsp_center_column;
   logic [12:0] rsp_run_width;
   logic [27:0] rsp_run_sum;
   logic [15:0] rsp_center_level;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   int errors;
   int pending;
   int quiet_cycles = 0;
   bit hold_go = 0;
   int star_left = 0;

   always #5 clock = ~clock;

   row_run_star_edge_detector dut (.*);
   row_run_star_edge_detector_checker checker_i (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] clamp16(input int v);
      return v > 65535 ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [15:0] make_pixel(input int thr, input int blk);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'($urandom);
      if (star_left == 0 && $urandom_range(0, 7) == 0) star_left = $urandom_range(1, 14);
      if (star_left > 0) begin
         star_left--;
         if ($urandom_range(0, 99) < 15) return clamp16(blk + $urandom_range(0, thr / 2));
         return clamp16(blk + thr + $urandom_range(0, 3000));
      end
      return clamp16(blk + $urandom_range(0, thr / 2));
   endfunction

   task automatic send_pixel(input logic [15:0] pixel, input logic frame_start);
      int gap;
      req_valid <= 1;
      req_pixel <= pixel;
      req_frame_start <= frame_start;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic settle();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic run_phase(input int thr, input int blk, input int bad, input int minw,
                            input int rowlen, input int count);
      settle();
      write_reg({1'b0, REG_THRESHOLD}, 16'(thr));
      write_reg({1'b0, REG_BLACK}, 16'(blk));
      write_reg({1'b0, REG_BAD_LIMIT}, 16'(bad));
      write_reg({1'b0, REG_MIN_WIDTH}, 16'(minw));
      write_reg(REG_ROW_LENGTH, 16'(rowlen));
      star_left = 0;
      for (int i = 0; i < count; i++)
         send_pixel(make_pixel(thr, blk), i == 0 || $urandom_range(0, 149) == 0);
   endtask

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int stall_pct;
      int hold_left;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
         end
         if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 25;
         if (hold_left > 0) begin
            hold_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            hold_left = pick_gap();
         end
         rsp_stall <= hold_left > 0;
      end
   end

   initial begin
      logic [15:0] opening[20] = '{16'd200, 16'd65535, 16'd3000, 16'd3000, 16'd150, 16'd150,
                                   16'd3000, 16'd100, 16'd100, 16'd100, 16'd1100, 16'd0,
                                   16'd5000, 16'd5000, 16'd6000, 16'd0, 16'd0, 16'd0,
                                   16'd4000, 16'd4000};
      repeat (6) @(posedge clock);
      reset <= 0;
      write_reg({1'b0, REG_THRESHOLD}, 16'd1000);
      write_reg({1'b0, REG_BLACK}, 16'd100);
      write_reg(REG_ROW_LENGTH, 16'd20);
      foreach (opening[i]) send_pixel(opening[i], i == 0);
      run_phase(1000, 100, 2, 3, 32, 350);
      hold_go = 1;
      for (int i = 0; i < 200; i++) send_pixel(make_pixel(1000, 100), 1'b0);
      run_phase(0, 0, 0, 0, 0, 40);
      run_phase(65535, 65535, 15, 4096, 4096, 40);
      run_phase(200, 0, 15, 1, 64, 300);
      run_phase(3000, 20000, 0, 5, 4096, 250);
      run_phase(1, 50, 7, 2, 5000, 150);
      run_phase(800, 300, 3, 0, 20, 300);
      settle();
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
